@@ hw/rtl/qte_pkg.sv @@
// ----------------------------------------------------------------------------
// qte_pkg
// Shared constants, types and address helpers of the quadtree encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qte_pkg;

	localparam int MAX_SIDE_LOG2 = 6;
	localparam int LEVEL_LIMIT   = 10;
	localparam int OFFSET_W      = 2 * LEVEL_LIMIT;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	localparam logic [1:0] SYM_OPEN  = 2'd2;
	localparam logic [1:0] SYM_CLOSE = 2'd3;

	typedef struct packed {
		logic uni;
		logic val;
	} summary_t;

	typedef struct packed {
		logic busy;
		logic full;
	} load_stat_t;

	typedef struct packed {
		logic pix_we;
		logic sum_we;
	} store_wr_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] symbol;
		logic       last;
		logic       error;
	} walk_res_t;

	// summaries of level d start after all nodes of the levels above it
	function automatic logic [OFFSET_W-1:0] node_addr(input logic [3:0] lvl,
		input logic [OFFSET_W-1:0] node);
		logic [OFFSET_W-1:0] off;
		off = '0;
		for (int j = 0; j < LEVEL_LIMIT; j++) begin
			if (j < int'(lvl)) begin
				off[2*j] = 1'b1;
			end
		end
		return off + node;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/qte_req_if.sv @@
// ----------------------------------------------------------------------------
// qte_req_if
// Input channel: load or fetch transactions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface qte_req_if;
	logic valid;
	logic ready;
	logic opcode;
	logic pixel;

	modport source (output valid, output opcode, output pixel, input ready);
	modport sink (input valid, input opcode, input pixel, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/qte_rsp_if.sv @@
// ----------------------------------------------------------------------------
// qte_rsp_if
// Output channel: encoded symbol transactions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface qte_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] symbol;
	logic       last;
	logic       error;

	modport source (output valid, output symbol, output last, output error, input ready);
	modport sink (input valid, input symbol, input last, input error, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/qte_store.sv @@
// ----------------------------------------------------------------------------
// qte_store
// Pixel memory and node summary memory, both in z-order, registered reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qte_store #(
	parameter  int MAX_SIDE_LOG2 = qte_pkg::MAX_SIDE_LOG2,
	localparam int PIX_AW        = 2 * MAX_SIDE_LOG2,
	localparam int PIX_DEPTH     = 1 << PIX_AW,
	localparam int SUM_DEPTH     = ((1 << PIX_AW) - 1) / 3,
	localparam int SUM_AW        = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1
) (
	input  wire logic                clk,
	input  wire qte_pkg::store_wr_t  wr,
	input  wire logic [PIX_AW-1:0]   pix_waddr,
	input  wire logic                pix_wdata,
	input  wire logic [PIX_AW-1:0]   pix_raddr,
	output logic                     pix_rdata,
	input  wire logic [SUM_AW-1:0]   sum_waddr,
	input  wire qte_pkg::summary_t   sum_wdata,
	input  wire logic [SUM_AW-1:0]   sum_raddr,
	output qte_pkg::summary_t        sum_rdata
);

	logic              pix_mem [PIX_DEPTH];
	qte_pkg::summary_t sum_mem [SUM_DEPTH];
	logic              pix_rd_q;
	qte_pkg::summary_t sum_rd_q;

	always_ff @(posedge clk) begin
		if (wr.pix_we) begin
			pix_mem[pix_waddr] <= pix_wdata;
		end
		pix_rd_q <= pix_mem[pix_raddr];
	end

	always_ff @(posedge clk) begin
		if (wr.sum_we) begin
			sum_mem[sum_waddr] <= sum_wdata;
		end
		sum_rd_q <= sum_mem[sum_raddr];
	end

	assign pix_rdata = pix_rd_q;
	assign sum_rdata = sum_rd_q;

endmodule

`default_nettype wire

@@ hw/rtl/qte_loader.sv @@
// ----------------------------------------------------------------------------
// qte_loader
// Writes each pixel and updates the summary of every enclosing node.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qte_loader #(
	parameter  int MAX_SIDE_LOG2 = qte_pkg::MAX_SIDE_LOG2,
	localparam int LGW           = $clog2(MAX_SIDE_LOG2 + 1),
	localparam int PIX_AW        = 2 * MAX_SIDE_LOG2,
	localparam int SUM_DEPTH     = ((1 << PIX_AW) - 1) / 3,
	localparam int SUM_AW        = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               restart,
	input  wire logic               start,
	input  wire logic               pixel,
	input  wire logic [LGW-1:0]     lg,
	output qte_pkg::load_stat_t     stat,
	output qte_pkg::store_wr_t      wr,
	output logic [PIX_AW-1:0]       pix_waddr,
	output logic                    pix_wdata,
	output logic [SUM_AW-1:0]       sum_waddr,
	output qte_pkg::summary_t       sum_wdata,
	output logic [SUM_AW-1:0]       sum_raddr,
	input  wire qte_pkg::summary_t  sum_rdata
);

	typedef enum logic [1:0] {L_IDLE, L_PIX, L_SWEEP} state_t;

	state_t                   state_q;
	logic [MAX_SIDE_LOG2-1:0] row_q;
	logic [MAX_SIDE_LOG2-1:0] col_q;
	logic                     full_q;
	logic                     px_q;
	logic [PIX_AW-1:0]        morton_q;
	logic [LGW-1:0]           lvl_s1;
	logic [PIX_AW-1:0]        node_s1;
	logic                     first_s1;

	logic [MAX_SIDE_LOG2-1:0] side_mask;
	logic [PIX_AW-1:0]        morton;
	logic [LGW-1:0]           rd_lvl;
	logic [PIX_AW-1:0]        rd_node;

	function automatic logic [PIX_AW-1:0] interleave(input logic [MAX_SIDE_LOG2-1:0] r,
		input logic [MAX_SIDE_LOG2-1:0] c);
		logic [PIX_AW-1:0] m;
		for (int i = 0; i < MAX_SIDE_LOG2; i++) begin
			m[2*i]   = c[i];
			m[2*i+1] = r[i];
		end
		return m;
	endfunction

	assign side_mask = ~({MAX_SIDE_LOG2{1'b1}} << lg);
	assign morton    = interleave(row_q, col_q);

	always_comb begin
		if (state_q == L_PIX) begin
			rd_lvl  = LGW'(lg - 1'b1);
			rd_node = morton_q >> 2;
		end else begin
			rd_lvl  = LGW'(lvl_s1 - 1'b1);
			rd_node = node_s1 >> 2;
		end
	end

	assign sum_raddr = SUM_AW'(qte_pkg::node_addr(4'(rd_lvl), qte_pkg::OFFSET_W'(rd_node)));
	assign sum_waddr = SUM_AW'(qte_pkg::node_addr(4'(lvl_s1), qte_pkg::OFFSET_W'(node_s1)));

	always_comb begin
		if (first_s1) begin
			sum_wdata.uni = 1'b1;
			sum_wdata.val = px_q;
		end else begin
			sum_wdata.uni = sum_rdata.uni && (sum_rdata.val == px_q);
			sum_wdata.val = sum_rdata.val;
		end
	end

	assign pix_waddr  = morton_q;
	assign pix_wdata  = px_q;
	assign wr.pix_we  = (state_q == L_PIX);
	assign wr.sum_we  = (state_q == L_SWEEP);
	assign stat.busy  = (state_q != L_IDLE);
	assign stat.full  = full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= L_IDLE;
			row_q    <= '0;
			col_q    <= '0;
			full_q   <= 1'b0;
			lvl_s1   <= '0;
			first_s1 <= 1'b0;
		end else if (restart) begin
			state_q <= L_IDLE;
			row_q   <= '0;
			col_q   <= '0;
			full_q  <= 1'b0;
		end else begin
			unique case (state_q)
				L_IDLE: begin
					if (start && !full_q) begin
						px_q     <= pixel;
						morton_q <= morton;
						state_q  <= L_PIX;
						if (col_q == side_mask) begin
							col_q <= '0;
							if (row_q == side_mask) begin
								row_q  <= '0;
								full_q <= 1'b1;
							end else begin
								row_q <= row_q + 1'b1;
							end
						end else begin
							col_q <= col_q + 1'b1;
						end
					end
				end
				L_PIX: begin
					if (lg == '0) begin
						state_q <= L_IDLE;
					end else begin
						lvl_s1   <= rd_lvl;
						node_s1  <= rd_node;
						first_s1 <= (morton_q[1:0] == 2'b00);
						state_q  <= L_SWEEP;
					end
				end
				L_SWEEP: begin
					if (lvl_s1 == '0) begin
						state_q <= L_IDLE;
					end else begin
						lvl_s1   <= rd_lvl;
						node_s1  <= rd_node;
						first_s1 <= first_s1 && (node_s1[1:0] == 2'b00);
					end
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/qte_walker.sv @@
// ----------------------------------------------------------------------------
// qte_walker
// Depth-first walk over the node summaries, one symbol per fetch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qte_walker #(
	parameter  int MAX_SIDE_LOG2 = qte_pkg::MAX_SIDE_LOG2,
	localparam int LGW           = $clog2(MAX_SIDE_LOG2 + 1),
	localparam int PIX_AW        = 2 * MAX_SIDE_LOG2,
	localparam int SUM_DEPTH     = ((1 << PIX_AW) - 1) / 3,
	localparam int SUM_AW        = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               restart,
	input  wire logic               start,
	input  wire logic [LGW-1:0]     lg,
	input  wire logic               full,
	input  wire logic               take,
	output logic                    busy,
	output qte_pkg::walk_res_t      res,
	output logic [PIX_AW-1:0]       pix_raddr,
	input  wire logic               pix_rdata,
	output logic [SUM_AW-1:0]       sum_raddr,
	input  wire qte_pkg::summary_t  sum_rdata
);

	typedef enum logic [1:0] {W_IDLE, W_STEP, W_DATA, W_HOLD} state_t;

	state_t            state_q;
	logic [LGW-1:0]    level_q;
	logic [PIX_AW-1:0] path_q;
	logic              after_q;
	logic              done_q;
	logic [1:0]        sym_q;
	logic              last_q;
	logic              err_q;

	logic              bump;
	logic              step_after;
	logic [PIX_AW-1:0] step_path;
	logic              at_leaf;
	qte_pkg::summary_t node_sum;

	// the low digit of the path is the child index at the current level
	assign bump       = after_q && (level_q != '0) && (path_q[1:0] != 2'd3);
	assign step_after = after_q && !bump;
	assign step_path  = path_q + PIX_AW'(bump);
	assign at_leaf    = (level_q >= lg);

	assign pix_raddr = step_path;
	assign sum_raddr = SUM_AW'(qte_pkg::node_addr(4'(level_q), qte_pkg::OFFSET_W'(step_path)));

	always_comb begin
		if (at_leaf) begin
			node_sum.uni = 1'b1;
			node_sum.val = pix_rdata;
		end else begin
			node_sum = sum_rdata;
		end
	end

	assign busy       = (state_q != W_IDLE);
	assign res.valid  = (state_q == W_HOLD);
	assign res.symbol = sym_q;
	assign res.last   = last_q;
	assign res.error  = err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
			level_q <= '0;
			path_q  <= '0;
			after_q <= 1'b0;
			done_q  <= 1'b0;
		end else if (restart) begin
			state_q <= W_IDLE;
			level_q <= '0;
			path_q  <= '0;
			after_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				W_IDLE: begin
					if (start) begin
						if (!full || done_q) begin
							sym_q   <= 2'd0;
							last_q  <= 1'b0;
							err_q   <= 1'b1;
							state_q <= W_HOLD;
						end else begin
							state_q <= W_STEP;
						end
					end
				end
				W_STEP: begin
					after_q <= step_after;
					err_q   <= 1'b0;
					if (!step_after) begin
						path_q  <= step_path;
						state_q <= W_DATA;
					end else begin
						// all four children done: close this node
						if (level_q != '0) begin
							level_q <= LGW'(level_q - 1'b1);
							path_q  <= step_path >> 2;
						end else begin
							path_q <= step_path;
						end
						sym_q   <= qte_pkg::SYM_CLOSE;
						last_q  <= (level_q <= LGW'(1));
						done_q  <= (level_q <= LGW'(1));
						state_q <= W_HOLD;
					end
				end
				W_DATA: begin
					if (node_sum.uni) begin
						sym_q   <= {1'b0, node_sum.val};
						after_q <= 1'b1;
						last_q  <= (level_q == '0);
						done_q  <= (level_q == '0);
					end else begin
						sym_q   <= qte_pkg::SYM_OPEN;
						last_q  <= 1'b0;
						level_q <= LGW'(level_q + 1'b1);
						path_q  <= path_q << 2;
					end
					state_q <= W_HOLD;
				end
				W_HOLD: begin
					if (take) begin
						state_q <= W_IDLE;
					end
				end
				default: state_q <= W_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/binary_image_quadtree_encoder_core.sv @@
// ----------------------------------------------------------------------------
// binary_image_quadtree_encoder_core
// Load: the next transaction waits until the loader has written the pixel and the
// summaries of its lg enclosing nodes, lg being side_log2 capped at the maximum.
// Fetch: the next fetch waits until the symbol has moved into the output register.
// Reset sets side_log2 to 0 and starts an empty load; memories are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module binary_image_quadtree_encoder_core #(
	parameter int MAX_SIDE_LOG2 = qte_pkg::MAX_SIDE_LOG2
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	qte_req_if.sink         req,
	qte_rsp_if.source       rsp,
	input  wire logic       cfg_we,
	input  wire logic [2:0] cfg_wdata
);

	localparam int LGW       = $clog2(MAX_SIDE_LOG2 + 1);
	localparam int PIX_AW    = 2 * MAX_SIDE_LOG2;
	localparam int SUM_DEPTH = ((1 << PIX_AW) - 1) / 3;
	localparam int SUM_AW    = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;

	logic [2:0]          side_q;
	logic [LGW-1:0]      lg;
	logic                accept;
	logic                ld_start;
	logic                wk_start;
	logic                take;

	qte_pkg::load_stat_t ld_stat;
	qte_pkg::store_wr_t  st_wr;
	logic [PIX_AW-1:0]   pix_waddr;
	logic                pix_wdata;
	logic [PIX_AW-1:0]   pix_raddr;
	logic                pix_rdata;
	logic [SUM_AW-1:0]   sum_waddr;
	qte_pkg::summary_t   sum_wdata;
	logic [SUM_AW-1:0]   ld_sum_raddr;
	logic [SUM_AW-1:0]   wk_sum_raddr;
	logic [SUM_AW-1:0]   sum_raddr;
	qte_pkg::summary_t   sum_rdata;

	logic                wk_busy;
	qte_pkg::walk_res_t  wk_res;

	logic                out_valid_q;
	logic [1:0]          out_symbol_q;
	logic                out_last_q;
	logic                out_error_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= '0;
		end else if (cfg_we) begin
			side_q <= cfg_wdata;
		end
	end

	assign lg = (int'(side_q) > MAX_SIDE_LOG2) ? LGW'(MAX_SIDE_LOG2) : LGW'(side_q);

	assign req.ready = !ld_stat.busy && !wk_busy;
	assign accept    = req.valid && req.ready;
	assign ld_start  = accept && (req.opcode == qte_pkg::OP_LOAD) && !ld_stat.full;
	assign wk_start  = accept && (req.opcode == qte_pkg::OP_FETCH);
	assign take      = wk_res.valid && (!out_valid_q || rsp.ready);
	assign sum_raddr = ld_stat.busy ? ld_sum_raddr : wk_sum_raddr;

	qte_store #(
		.MAX_SIDE_LOG2 (MAX_SIDE_LOG2)
	) u_store (
		.clk       (clk),
		.wr        (st_wr),
		.pix_waddr (pix_waddr),
		.pix_wdata (pix_wdata),
		.pix_raddr (pix_raddr),
		.pix_rdata (pix_rdata),
		.sum_waddr (sum_waddr),
		.sum_wdata (sum_wdata),
		.sum_raddr (sum_raddr),
		.sum_rdata (sum_rdata)
	);

	qte_loader #(
		.MAX_SIDE_LOG2 (MAX_SIDE_LOG2)
	) u_loader (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (cfg_we),
		.start     (ld_start),
		.pixel     (req.pixel),
		.lg        (lg),
		.stat      (ld_stat),
		.wr        (st_wr),
		.pix_waddr (pix_waddr),
		.pix_wdata (pix_wdata),
		.sum_waddr (sum_waddr),
		.sum_wdata (sum_wdata),
		.sum_raddr (ld_sum_raddr),
		.sum_rdata (sum_rdata)
	);

	qte_walker #(
		.MAX_SIDE_LOG2 (MAX_SIDE_LOG2)
	) u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (cfg_we),
		.start     (wk_start),
		.lg        (lg),
		.full      (ld_stat.full),
		.take      (take),
		.busy      (wk_busy),
		.res       (wk_res),
		.pix_raddr (pix_raddr),
		.pix_rdata (pix_rdata),
		.sum_raddr (wk_sum_raddr),
		.sum_rdata (sum_rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_symbol_q <= wk_res.symbol;
			out_last_q   <= wk_res.last;
			out_error_q  <= wk_res.error;
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.symbol = out_symbol_q;
	assign rsp.last   = out_last_q;
	assign rsp.error  = out_error_q;

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives load and fetch transactions into the quadtree encoder with random
// idle cycles on both channels, tracks the expected symbol stream in a small
// scoreboard and compares every symbol transaction field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam int STORE_DEPTH  = 1 << (2 * qte_pkg::MAX_SIDE_LOG2);
	localparam int RANDOM_ITEMS = 950;
	localparam int HOLD_CYCLES  = 300;
	localparam int SETTLE       = 20;
	localparam int IDLE_LIMIT   = 5000;

	typedef enum logic [1:0] {ENC_LOAD, ENC_WALK, ENC_DONE} enc_phase_t;

	typedef struct packed {
		logic [1:0] symbol;
		logic       last;
		logic       error;
	} sym_rec_t;

	class quadtree_tracker;
		bit          pix [0:STORE_DEPTH-1];
		int          fill_count;
		bit [1:0]    branch [0:qte_pkg::MAX_SIDE_LOG2];
		int          depth;
		enc_phase_t  phase = ENC_LOAD;
		bit          node_done;
		bit [2:0]    side_code;
		sym_rec_t    pending [$];
		int          errors;

		function int eff_log2();
			return (side_code > qte_pkg::MAX_SIDE_LOG2) ? qte_pkg::MAX_SIDE_LOG2
				: int'(side_code);
		endfunction

		function void set_side(bit [2:0] code);
			side_code  = code;
			fill_count = 0;
			depth      = 0;
			phase      = ENC_LOAD;
			node_done  = 1'b0;
			foreach (branch[i]) branch[i] = '0;
		endfunction

		function bit walking();
			return phase == ENC_WALK;
		endfunction

		function bit waiting();
			return pending.size() > 0;
		endfunction

		// uniformity of the block under the current walk position
		function bit block_uniform(output bit v);
			int lg, side, r, c, n;
			lg   = eff_log2();
			side = 1 << lg;
			r    = 0;
			c    = 0;
			for (int d = 1; d <= depth && d <= lg; d++) begin
				r += branch[d][1] * (side >> d);
				c += branch[d][0] * (side >> d);
			end
			n = side >> ((depth <= lg) ? depth : lg);
			v = pix[(r * side + c) & (STORE_DEPTH - 1)];
			for (int i = r; i < r + n; i++)
				for (int j = c; j < c + n; j++)
					if (pix[(i * side + j) & (STORE_DEPTH - 1)] != v)
						return 1'b0;
			return 1'b1;
		endfunction

		function void note_item(logic op, logic px);
			int       lg, total;
			bit       v, uni;
			sym_rec_t rec;
			lg    = eff_log2();
			total = 1 << (2 * lg);
			if (op == qte_pkg::OP_LOAD) begin
				if (phase == ENC_LOAD && fill_count < total) begin
					pix[fill_count & (STORE_DEPTH - 1)] = px;
					fill_count++;
					if (fill_count == total) begin
						phase     = ENC_WALK;
						depth     = 0;
						node_done = 1'b0;
					end
				end
				return;
			end
			rec = '0;
			if (phase != ENC_WALK) begin
				rec.error = 1'b1;
				pending.push_back(rec);
				return;
			end
			if (node_done && depth > 0 && branch[depth] < 3) begin
				branch[depth]++;
				node_done = 1'b0;
			end
			if (!node_done) begin
				uni = block_uniform(v);
				if (uni || depth >= lg) begin
					rec.symbol = {1'b0, v};
					node_done  = 1'b1;
				end else begin
					rec.symbol = qte_pkg::SYM_OPEN;
					depth++;
					branch[depth] = '0;
				end
			end else begin
				// all four quadrants emitted
				if (depth > 0)
					depth--;
				rec.symbol = qte_pkg::SYM_CLOSE;
				node_done  = 1'b1;
			end
			rec.last = node_done && depth == 0;
			if (rec.last)
				phase = ENC_DONE;
			pending.push_back(rec);
		endfunction

		function void check_symbol(logic [1:0] s, logic l, logic e);
			sym_rec_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected transaction at %0t: symbol %0d last %0b error %0b",
						$time, s, l, e);
				return;
			end
			want = pending.pop_front();
			if (s !== want.symbol || l !== want.last || e !== want.error) begin
				errors++;
				if (errors <= 10)
					$display("mismatch at %0t: symbol %0d/%0d last %0b/%0b error %0b/%0b",
						$time, want.symbol, s, want.last, l, want.error, e);
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [2:0] cfg_wdata;

	qte_req_if req();
	qte_rsp_if rsp();

	quadtree_tracker board;
	bit   image [0:STORE_DEPTH-1];
	bit   calm;
	bit   hold_rsp;
	int   items_sent;

	binary_image_quadtree_encoder_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #2 clk = ~clk;

	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(0, 7);
	endfunction

	function automatic logic coin();
		return 1'($urandom_range(0, 1));
	endfunction

	task automatic send_item(input logic op, input logic px);
		int gap;
		gap = draw_gap();
		@(negedge clk);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid  <= 1'b1;
		req.opcode <= op;
		req.pixel  <= px;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		board.note_item(op, px);
	endtask

	// sender stops until every symbol has come back, then lets the block settle
	task automatic drain();
		@(negedge clk);
		req.valid <= 1'b0;
		while (board.waiting()) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_side(input bit [2:0] code);
		drain();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= code;
		@(posedge clk);
		board.set_side(code);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// blocky random image with sparse single-pixel noise (per mille)
	function automatic void make_image(int lg, int grain, int noise);
		bit tone [0:STORE_DEPTH-1];
		int g, r, c;
		g = (grain > lg) ? lg : grain;
		foreach (tone[i]) tone[i] = coin();
		for (int i = 0; i < (1 << (2 * lg)); i++) begin
			r = i >> lg;
			c = i & ((1 << lg) - 1);
			image[i] = tone[((r >> g) << (lg - g)) + (c >> g)]
				^ ($urandom_range(0, 999) < noise);
		end
	endfunction

	task automatic run_image(input bit [2:0] code, input int grain, input int noise,
		input bit abort_ok, input bit stall);
		int lg, total, mode, stop_at, cut, fetched;
		lg    = (code > qte_pkg::MAX_SIDE_LOG2) ? qte_pkg::MAX_SIDE_LOG2 : int'(code);
		total = 1 << (2 * lg);
		mode  = abort_ok ? $urandom_range(0, 9) : 9;
		write_side(code);
		make_image(lg, grain, noise);
		stop_at = (mode == 0) ? $urandom_range(0, total - 1) : total;
		for (int i = 0; i < stop_at; i++) begin
			if ($urandom_range(0, 15) == 0) begin
				send_item(qte_pkg::OP_FETCH, coin());
				items_sent++;
			end
			send_item(qte_pkg::OP_LOAD, image[i]);
			items_sent++;
		end
		if (mode == 0)
			return;
		if (stall)
			hold_rsp = 1'b1;
		cut     = $urandom_range(1, 6);
		fetched = 0;
		while (board.walking()) begin
			if (mode == 1 && fetched == cut)
				return;
			send_item(qte_pkg::OP_FETCH, coin());
			fetched++;
			items_sent++;
		end
		case ($urandom_range(0, 3))
			1: begin
				send_item(qte_pkg::OP_FETCH, coin());
				items_sent++;
			end
			2: send_item(qte_pkg::OP_LOAD, coin());
			3: begin
				send_item(qte_pkg::OP_LOAD, coin());
				send_item(qte_pkg::OP_FETCH, coin());
				items_sent++;
			end
			default: ;
		endcase
	endtask

	// partial load of a large image, then an early fetch
	task automatic part_load(input bit [2:0] code, input int count);
		write_side(code);
		for (int i = 0; i < count; i++) begin
			send_item(qte_pkg::OP_LOAD, coin());
			items_sent++;
		end
		send_item(qte_pkg::OP_FETCH, coin());
		items_sent++;
	endtask

	// symbol receiver
	initial begin
		int gap;
		rsp.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			gap = draw_gap();
			if (hold_rsp) begin
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_rsp = 1'b0;
			end else if (gap > 0) begin
				rsp.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
			while (!rsp.valid) @(posedge clk);
			board.check_symbol(rsp.symbol, rsp.last, rsp.error);
		end
	end

	// watchdog on cycles without any transaction
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle = 0;
			else
				idle++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		bit [2:0] sizes [10];
		bit [2:0] code;
		int       phase_no;
		sizes      = '{3'd0, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd4};
		board      = new;
		calm       = 1'b0;
		hold_rsp   = 1'b0;
		items_sent = 0;
		arst_n     = 1'b0;
		req.valid  = 1'b0;
		req.opcode = qte_pkg::OP_LOAD;
		req.pixel  = 1'b0;
		cfg_we     = 1'b0;
		cfg_wdata  = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// single pixel image after reset: early fetch, fetch past the end, late load
		send_item(qte_pkg::OP_FETCH, 1'b1);
		send_item(qte_pkg::OP_LOAD, 1'b1);
		send_item(qte_pkg::OP_FETCH, 1'b0);
		send_item(qte_pkg::OP_FETCH, 1'b1);
		send_item(qte_pkg::OP_LOAD, 1'b0);
		send_item(qte_pkg::OP_FETCH, 1'b0);

		// mixed two by two image with a fetch in the middle of the load
		write_side(3'd1);
		send_item(qte_pkg::OP_LOAD, 1'b1);
		send_item(qte_pkg::OP_LOAD, 1'b0);
		send_item(qte_pkg::OP_FETCH, 1'b1);
		send_item(qte_pkg::OP_LOAD, 1'b0);
		send_item(qte_pkg::OP_LOAD, 1'b1);
		repeat (7) send_item(qte_pkg::OP_FETCH, coin());

		// uniform two by two image
		write_side(3'd1);
		repeat (4) send_item(qte_pkg::OP_LOAD, 1'b0);
		repeat (2) send_item(qte_pkg::OP_FETCH, 1'b1);

		phase_no = 0;
		while (items_sent < RANDOM_ITEMS) begin
			calm = ($urandom_range(0, 3) == 0);
			if (phase_no == 2) begin
				run_image(3'd3, 0, 100, 1'b0, 1'b1);
			end else begin
				code = sizes[$urandom_range(0, 9)];
				run_image(code, $urandom_range(0, code), $urandom_range(0, 60), 1'b1, 1'b0);
			end
			phase_no++;
		end

		calm = 1'b0;
		part_load(3'd7, 40);
		part_load(3'd6, 24);
		run_image(3'd0, 0, 0, 1'b0, 1'b0);

		drain();
		if (board.errors == 0 && !board.waiting())
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
